[src/shunting_yard_infix_to_postfix_top_assert.svh]
// assertion macros used by the checker of the infix to postfix block
`ifndef SHUNTING_YARD_INFIX_TO_POSTFIX_TOP_ASSERT_SVH
`define SHUNTING_YARD_INFIX_TO_POSTFIX_TOP_ASSERT_SVH

// same-cycle implication
`define SYI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("syi check failed");

// next-cycle implication
`define SYI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("syi check failed");

`endif

[src/syi_pkg.sv]
// ----------------------------------------------------------------------------
// syi_pkg
// types, token codes and constants of the infix to postfix converter
// ----------------------------------------------------------------------------
package syi_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 40;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    // input token kinds
    localparam logic [2:0] K_VALUE = 3'd0;
    localparam logic [2:0] K_VAR   = 3'd1;
    localparam logic [2:0] K_FUNC  = 3'd2;
    localparam logic [2:0] K_COMMA = 3'd3;
    localparam logic [2:0] K_OP    = 3'd4;
    localparam logic [2:0] K_LPAR  = 3'd5;
    localparam logic [2:0] K_RPAR  = 3'd6;
    localparam logic [2:0] K_END   = 3'd7;

    // result kinds
    localparam logic [2:0] OUT_FUNC   = 3'd2;
    localparam logic [2:0] OUT_OP     = 3'd3;
    localparam logic [2:0] OUT_STATUS = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_RPAR_EMPTY  = 3'd1;
    localparam logic [2:0] ERR_UNMATCHED_R = 3'd2;
    localparam logic [2:0] ERR_UNMATCHED_L = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UMINUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPREC  = 2'd3;

    localparam logic [7:0] MINUS_RST  = 8'd45;
    localparam logic [7:0] PLUS_RST   = 8'd43;
    localparam logic [7:0] UMINUS_RST = 8'd126;
    localparam logic [2:0] UPREC_RST  = 3'd5;

    typedef enum logic [1:0] {
        E_FUNC,
        E_OP,
        E_LPAR
    } t_ent_kind;

    typedef struct packed {
        t_ent_kind   kind;
        logic [31:0] payload;
        logic [2:0]  prec;
        logic        lassoc;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic       pop;
        logic       emit;
        logic       found;
        logic       finish;
        logic [2:0] err;
    } t_pop_dec;

endpackage

[src/syi_ram.sv]
// ----------------------------------------------------------------------------
// syi_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module syi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/syi_pop_unit.sv]
// ----------------------------------------------------------------------------
// syi_pop_unit
// compares the current token against the stack top and decides one pop step
// ----------------------------------------------------------------------------
module syi_pop_unit (
    input  logic [2:0]        i_tok_kind,
    input  logic [2:0]        i_tok_prec,
    input  logic              i_tok_lassoc,
    input  logic              i_found,
    input  syi_pkg::t_entry   i_top,
    output syi_pkg::t_pop_dec o_dec
);
    import syi_pkg::*;

    logic w_higher;

    assign w_higher = (i_tok_prec < i_top.prec) ||
                      (i_tok_lassoc && (i_tok_prec == i_top.prec));

    always_comb begin
        o_dec = '0;
        case (i_tok_kind)
            K_COMMA: begin
                if (i_top.kind == E_LPAR) begin
                    o_dec.finish = 1'b1;
                end else begin
                    o_dec.pop  = 1'b1;
                    o_dec.emit = 1'b1;
                end
            end
            K_OP: begin
                if (i_top.kind == E_OP && w_higher) begin
                    o_dec.pop  = 1'b1;
                    o_dec.emit = 1'b1;
                end else begin
                    o_dec.finish = 1'b1;
                end
            end
            K_END: begin
                if (i_top.kind == E_LPAR) begin
                    o_dec.finish = 1'b1;
                    o_dec.err    = ERR_UNMATCHED_L;
                end else begin
                    o_dec.pop  = 1'b1;
                    o_dec.emit = 1'b1;
                end
            end
            K_RPAR: begin
                if (i_found) begin
                    // function lying beneath the matched parenthesis
                    o_dec.finish = 1'b1;
                    if (i_top.kind == E_FUNC) begin
                        o_dec.pop  = 1'b1;
                        o_dec.emit = 1'b1;
                    end
                end else begin
                    o_dec.pop = 1'b1;
                    if (i_top.kind == E_LPAR) begin
                        o_dec.found = 1'b1;
                    end else begin
                        o_dec.emit = 1'b1;
                    end
                end
            end
            default: begin
                o_dec.finish = 1'b1;
            end
        endcase
    end

endmodule

[src/shunting_yard_infix_to_postfix_top.sv]
// ----------------------------------------------------------------------------
// shunting_yard_infix_to_postfix_top
// Converts infix tokens to postfix tokens over a bounded operator stack held
// in a small ram with registered read. One token is taken at a time;
// o_s_tready is high only while the converter is idle. A value or variable
// passes straight to the result stage, a function or left parenthesis is pushed,
// and every stack entry examined takes a stack read, then a compare in the
// shared pop unit; an operator pops entries and is then pushed. An error that
// follows popped tokens first sends the last popped token, then the status,
// and an output stall holds the converter. Each token yields at least one
// result transaction, the final one marked by tlast; a token that emits
// nothing yields a status result with kind 4.
// ----------------------------------------------------------------------------
module shunting_yard_infix_to_postfix_top #(
    parameter int STACK_DEPTH = syi_pkg::STACK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: payload[31:0], precedence[34:32], left_assoc[35], zero pad
    input  logic [syi_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: token_kind[2:0]
    input  logic [2:0]                        i_s_tuser,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: out_payload[31:0], error[34:32], zero pad
    output logic [syi_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // tuser: out_kind[2:0]
    output logic [2:0]                        o_m_tuser,
    output logic                              o_m_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_cfg_wen,
    input  logic [syi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [syi_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import syi_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PUSH,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [2:0]  r_tok_kind;
    logic [31:0] r_tok_payload;
    logic [2:0]  r_tok_prec;
    logic        r_tok_lassoc;
    logic [CW-1:0] r_count;
    logic [2:0]  r_prev;
    logic        r_found;
    logic [2:0]  r_err;
    logic        r_hold_v;
    logic [2:0]  r_hold_kind;
    logic [31:0] r_hold_payload;
    logic        r_m_valid;
    logic [2:0]  r_m_kind;
    logic [31:0] r_m_payload;
    logic [2:0]  r_m_err;
    logic        r_m_last;
    logic [7:0]  r_minus;
    logic [7:0]  r_plus;
    logic [7:0]  r_uminus;
    logic [2:0]  r_uprec;

    logic        w_accept;
    logic        w_out_free;
    logic        w_eval_go;
    logic        w_m_load;
    logic        w_lead;
    logic        w_unary;
    logic        w_skip;
    logic [31:0] w_in_payload;
    logic [2:0]  w_in_prec;
    logic        w_in_lassoc;
    logic [CW-1:0] w_count_m1;
    logic        w_ram_we;
    logic        w_ram_re;
    t_entry      w_wr_entry;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry      w_top;
    t_pop_dec    w_dec;
    logic [2:0]  w_top_out_kind;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_count_m1 = r_count - CW'(1);
    assign w_eval_go  = !(w_dec.emit && r_hold_v && !w_out_free);
    assign w_m_load   = ((r_state == S_EVAL) && w_eval_go && w_dec.emit && r_hold_v) ||
                        ((r_state == S_DONE) && w_out_free);

    // operator rewrite in leading position
    always_comb begin
        w_lead       = r_prev inside {K_END, K_OP, K_COMMA, K_LPAR};
        w_unary      = w_lead && (i_s_tuser == K_OP) &&
                       (i_s_tdata[31:0] == {24'd0, r_minus});
        w_skip       = w_lead && !w_unary && (i_s_tdata[31:0] == {24'd0, r_plus});
        w_in_payload = w_unary ? {24'd0, r_uminus} : i_s_tdata[31:0];
        w_in_prec    = w_unary ? r_uprec : i_s_tdata[34:32];
        w_in_lassoc  = w_unary ? 1'b0 : i_s_tdata[35];
    end

    always_comb begin
        w_wr_entry.payload = r_tok_payload;
        w_wr_entry.prec    = r_tok_prec;
        w_wr_entry.lassoc  = r_tok_lassoc;
        case (r_tok_kind)
            K_FUNC:  w_wr_entry.kind = E_FUNC;
            K_LPAR:  w_wr_entry.kind = E_LPAR;
            default: w_wr_entry.kind = E_OP;
        endcase
    end

    assign w_ram_we = (r_state == S_PUSH);
    assign w_ram_re = (r_state == S_READ);
    assign w_top    = t_entry'(w_rdata);
    assign w_top_out_kind = (w_top.kind == E_FUNC) ? OUT_FUNC : OUT_OP;

    syi_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wr_entry),
        .i_re    (w_ram_re),
        .i_raddr (w_count_m1[AW-1:0]),
        .o_rdata (w_rdata)
    );

    syi_pop_unit u_pop (
        .i_tok_kind   (r_tok_kind),
        .i_tok_prec   (r_tok_prec),
        .i_tok_lassoc (r_tok_lassoc),
        .i_found      (r_found),
        .i_top        (w_top),
        .o_dec        (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minus  <= MINUS_RST;
            r_plus   <= PLUS_RST;
            r_uminus <= UMINUS_RST;
            r_uprec  <= UPREC_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_MINUS:  r_minus  <= i_cfg_wdata;
                CFG_PLUS:   r_plus   <= i_cfg_wdata;
                CFG_UMINUS: r_uminus <= i_cfg_wdata;
                CFG_UPREC:  r_uprec  <= i_cfg_wdata[2:0];
                default:    r_uprec  <= r_uprec;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_prev    <= K_END;
            r_found   <= 1'b0;
            r_err     <= ERR_NONE;
            r_hold_v  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_m_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tok_kind    <= i_s_tuser;
                        r_tok_payload <= w_in_payload;
                        r_tok_prec    <= w_in_prec;
                        r_tok_lassoc  <= w_in_lassoc;
                        r_found       <= 1'b0;
                        case (i_s_tuser)
                            K_VALUE, K_VAR: begin
                                r_err          <= ERR_NONE;
                                r_hold_v       <= 1'b1;
                                r_hold_kind    <= i_s_tuser;
                                r_hold_payload <= i_s_tdata[31:0];
                                r_state        <= S_DONE;
                            end
                            K_FUNC, K_LPAR: begin
                                if (r_count == FULL) begin
                                    r_err   <= ERR_OVERFLOW;
                                    r_state <= S_DONE;
                                end else begin
                                    r_err   <= ERR_NONE;
                                    r_state <= S_PUSH;
                                end
                            end
                            K_OP: begin
                                r_err <= ERR_NONE;
                                if (w_skip) begin
                                    r_state <= S_DONE;
                                end else if (r_count == '0) begin
                                    r_state <= S_PUSH;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            K_RPAR: begin
                                if (r_count == '0) begin
                                    r_err   <= ERR_RPAR_EMPTY;
                                    r_state <= S_DONE;
                                end else begin
                                    r_err   <= ERR_NONE;
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_err   <= ERR_NONE;
                                r_state <= (r_count == '0) ? S_DONE : S_READ;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_eval_go) begin
                        if (w_dec.emit) begin
                            r_hold_v       <= 1'b1;
                            r_hold_kind    <= w_top_out_kind;
                            r_hold_payload <= w_top.payload;
                            if (r_hold_v) begin
                                r_m_kind    <= r_hold_kind;
                                r_m_payload <= r_hold_payload;
                                r_m_err     <= ERR_NONE;
                                r_m_last    <= 1'b0;
                            end
                        end
                        if (w_dec.pop) begin
                            r_count <= w_count_m1;
                        end
                        r_found <= r_found | w_dec.found;
                        if (w_dec.finish) begin
                            if (w_dec.err != ERR_NONE) begin
                                r_err   <= w_dec.err;
                                r_state <= S_DONE;
                            end else if (r_tok_kind == K_OP) begin
                                if (r_count == FULL) begin
                                    r_err   <= ERR_OVERFLOW;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_PUSH;
                                end
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else if (w_count_m1 == '0) begin
                            if (r_tok_kind == K_OP) begin
                                r_state <= S_PUSH;
                            end else begin
                                if (r_tok_kind == K_RPAR && !(r_found | w_dec.found)) begin
                                    r_err <= ERR_UNMATCHED_R;
                                end
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_PUSH: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_hold_v  <= 1'b0;
                        if (r_err != ERR_NONE && r_hold_v) begin
                            r_m_kind    <= r_hold_kind;
                            r_m_payload <= r_hold_payload;
                            r_m_err     <= ERR_NONE;
                            r_m_last    <= 1'b0;
                        end else begin
                            r_m_last <= 1'b1;
                            if (r_hold_v) begin
                                r_m_kind    <= r_hold_kind;
                                r_m_payload <= r_hold_payload;
                                r_m_err     <= ERR_NONE;
                            end else begin
                                r_m_kind    <= OUT_STATUS;
                                r_m_payload <= '0;
                                r_m_err     <= r_err;
                            end
                            if (r_err != ERR_NONE) begin
                                r_count <= '0;
                                r_prev  <= K_END;
                            end else begin
                                r_prev <= r_tok_kind;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - 35)'(0), r_m_err, r_m_payload};
    assign o_m_tuser  = r_m_kind;
    assign o_m_tlast  = r_m_last;

endmodule

[src/syi_checker.sv]
// ----------------------------------------------------------------------------
// syi_checker
// port-level checks of the infix to postfix converter, bound to the top level
// ----------------------------------------------------------------------------
`include "shunting_yard_infix_to_postfix_top_assert.svh"

module syi_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic [syi_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic [2:0]                      i_s_tuser,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [syi_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [2:0]                      o_m_tuser,
    input logic                            o_m_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic                            i_cfg_wen,
    input logic [syi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [syi_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import syi_pkg::*;

    // one token at a time
    `SYI_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    `SYI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))

    // an error ends the token's results as a status transaction
    `SYI_ASSERT_IMP(a_err_is_status, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[34:32] != ERR_NONE), o_m_tlast && (o_m_tuser == OUT_STATUS))

    `SYI_ASSERT_IMP(a_token_no_err, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != OUT_STATUS), o_m_tdata[34:32] == ERR_NONE)

endmodule

bind shunting_yard_infix_to_postfix_top syi_checker u_syi_checker (.*);

[verif/shunting_yard_infix_to_postfix_checker.sv]
// ----------------------------------------------------------------------------
// shunting_yard_infix_to_postfix_checker
// Watches the token, postfix and register write ports of the converter. Each
// accepted token is run through a local shunting-yard model with its own
// operator stack and register copies; the postfix transactions it should cause
// are queued and compared field by field with what the block emits.
// ----------------------------------------------------------------------------
module shunting_yard_infix_to_postfix_checker
    import syi_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [2:0]             i_s_tuser,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [2:0]             i_m_tuser,
    input  logic                   i_m_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic                   i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_result_count,
    output int                     o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] payload;
        logic        last;
        logic [2:0]  err;
    } t_postfix;

    t_entry      op_stk [DEPTH];
    int unsigned stk_cnt;
    logic [2:0]  prev_tok;
    logic [7:0]  minus_cfg;
    logic [7:0]  plus_cfg;
    logic [7:0]  uminus_cfg;
    logic [2:0]  uprec_cfg;
    t_postfix    postfix_q[$];
    int          fails;
    int          results;
    int          err_results;

    initial begin
        fails          = 0;
        results        = 0;
        err_results    = 0;
    end

    function automatic t_postfix make_result(logic [2:0] k, logic [31:0] p, logic [2:0] e);
        t_postfix r;
        r.kind    = k;
        r.payload = p;
        r.last    = 1'b0;
        r.err     = e;
        return r;
    endfunction

    function automatic t_postfix entry_result(t_entry e);
        return make_result((e.kind == E_FUNC) ? OUT_FUNC : OUT_OP, e.payload, ERR_NONE);
    endfunction

    function automatic bit stack_push(t_ent_kind ek, logic [31:0] p, logic [2:0] pr, logic la);
        t_entry e;
        if (stk_cnt >= DEPTH)
            return 1'b0;
        e.kind    = ek;
        e.payload = p;
        e.prec    = pr;
        e.lassoc  = la;
        op_stk[stk_cnt] = e;
        stk_cnt++;
        return 1'b1;
    endfunction

    // stacked operator that must leave before the incoming one is pushed
    function automatic bit outranks(t_entry e, logic [2:0] pr, logic la);
        return (e.kind == E_OP) && ((la && pr == e.prec) || pr < e.prec);
    endfunction

    function automatic void convert_token(logic [2:0] kind, logic [31:0] pl, logic [2:0] pr,
                                          logic la);
        t_postfix   outs[$];
        logic [2:0] err;
        bit         lead;
        bit         skip;
        bit         found;
        err   = ERR_NONE;
        skip  = 1'b0;
        found = 1'b0;
        lead  = (prev_tok == K_END) || (prev_tok == K_OP) || (prev_tok == K_COMMA) ||
                (prev_tok == K_LPAR);
        case (kind)
            K_VALUE, K_VAR: begin
                outs.insert(outs.size(), make_result(kind, pl, ERR_NONE));
            end
            K_FUNC, K_LPAR: begin
                if (!stack_push((kind == K_FUNC) ? E_FUNC : E_LPAR, pl, 3'd0, 1'b0))
                    err = ERR_OVERFLOW;
            end
            K_COMMA: begin
                while (stk_cnt > 0 && op_stk[stk_cnt-1].kind != E_LPAR) begin
                    stk_cnt--;
                    outs.insert(outs.size(), entry_result(op_stk[stk_cnt]));
                end
            end
            K_OP: begin
                if (pl == {24'd0, minus_cfg} && lead) begin
                    pl = {24'd0, uminus_cfg};
                    pr = uprec_cfg;
                    la = 1'b0;
                end else if (pl == {24'd0, plus_cfg} && lead) begin
                    skip = 1'b1;
                end
                if (!skip) begin
                    while (stk_cnt > 0 && outranks(op_stk[stk_cnt-1], pr, la)) begin
                        stk_cnt--;
                        outs.insert(outs.size(), entry_result(op_stk[stk_cnt]));
                    end
                    if (!stack_push(E_OP, pl, pr, la))
                        err = ERR_OVERFLOW;
                end
            end
            K_RPAR: begin
                if (stk_cnt == 0) begin
                    err = ERR_RPAR_EMPTY;
                end else begin
                    while (stk_cnt > 0 && !found) begin
                        stk_cnt--;
                        if (op_stk[stk_cnt].kind == E_LPAR)
                            found = 1'b1;
                        else
                            outs.insert(outs.size(), entry_result(op_stk[stk_cnt]));
                    end
                    if (stk_cnt > 0 && op_stk[stk_cnt-1].kind == E_FUNC) begin
                        stk_cnt--;
                        outs.insert(outs.size(), entry_result(op_stk[stk_cnt]));
                    end
                    if (!found)
                        err = ERR_UNMATCHED_R;
                end
            end
            default: begin
                while (stk_cnt > 0 && err == ERR_NONE) begin
                    if (op_stk[stk_cnt-1].kind == E_LPAR) begin
                        err = ERR_UNMATCHED_L;
                    end else begin
                        stk_cnt--;
                        outs.insert(outs.size(), entry_result(op_stk[stk_cnt]));
                    end
                end
            end
        endcase
        if (err != ERR_NONE) begin
            stk_cnt  = 0;
            prev_tok = K_END;
            outs.insert(outs.size(), make_result(OUT_STATUS, 32'd0, err));
        end else begin
            prev_tok = kind;
            if (outs.size() == 0)
                outs.insert(outs.size(), make_result(OUT_STATUS, 32'd0, ERR_NONE));
        end
        outs[outs.size()-1].last = 1'b1;
        foreach (outs[i])
            postfix_q.insert(postfix_q.size(), outs[i]);
    endfunction

    always @(posedge i_clk) begin
        t_postfix got;
        t_postfix want;
        if (!i_rst_n) begin
            stk_cnt    = 0;
            prev_tok   = K_END;
            minus_cfg  = MINUS_RST;
            plus_cfg   = PLUS_RST;
            uminus_cfg = UMINUS_RST;
            uprec_cfg  = UPREC_RST;
            postfix_q.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_MINUS:  minus_cfg  = i_cfg_wdata;
                    CFG_PLUS:   plus_cfg   = i_cfg_wdata;
                    CFG_UMINUS: uminus_cfg = i_cfg_wdata;
                    CFG_UPREC:  uprec_cfg  = i_cfg_wdata[2:0];
                    default:    uprec_cfg  = uprec_cfg;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                convert_token(i_s_tuser, i_s_tdata[31:0], i_s_tdata[34:32], i_s_tdata[35]);
            if (i_m_tvalid && i_m_tready) begin
                got.kind    = i_m_tuser;
                got.payload = i_m_tdata[31:0];
                got.last    = i_m_tlast;
                got.err     = i_m_tdata[34:32];
                results++;
                if (got.err != ERR_NONE)
                    err_results++;
                if (postfix_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected transaction kind %0d payload %h last %0b err %0d",
                             $time, got.kind, got.payload, got.last, got.err);
                end else begin
                    want = postfix_q.pop_front();
                    if (got !== want || i_m_tdata[OUT_TDATA_W-1:35] !== '0) begin
                        fails++;
                        $display("%0t: mismatch expected kind %0d payload %h last %0b err %0d",
                                 $time, want.kind, want.payload, want.last, want.err);
                        $display("%0t:          actual   kind %0d payload %h last %0b err %0d pad %h",
                                 $time, got.kind, got.payload, got.last, got.err,
                                 i_m_tdata[OUT_TDATA_W-1:35]);
                    end
                end
            end
        end
        o_pending      <= postfix_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
        o_error_count  <= err_results;
    end

endmodule

[verif/shunting_yard_infix_to_postfix_top_test.sv]
// ----------------------------------------------------------------------------
// shunting_yard_infix_to_postfix_top_test
// Drives infix token streams into the converter: a directed opening, then
// random well-formed expressions, deep nesting that may overflow the stack and
// random noise, over several register settings and handshake idle patterns,
// including a long output hold-off. The checker judges every transaction.
// ----------------------------------------------------------------------------
module shunting_yard_infix_to_postfix_top_test;
    import syi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] pl;
        logic [2:0]  pr;
        logic        la;
    } t_token;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [2:0]             s_tuser   = K_VALUE;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx   = CFG_MINUS;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int         fail_count;
    int         pending;
    int         result_count;
    int         error_count;
    int         n_sent      = 0;
    int         tx_pct      = 0;
    int         rx_pct      = 0;
    bit         hold_req    = 1'b0;
    int         idle_cycles = 0;
    logic [7:0] cur_minus   = MINUS_RST;
    logic [7:0] cur_plus    = PLUS_RST;
    t_token     tok_q[$];

    always #5 clk = ~clk;

    shunting_yard_infix_to_postfix_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    shunting_yard_infix_to_postfix_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_cfg_wen     (cfg_wen),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_error_count (error_count)
    );

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_tok(logic [2:0] kind, logic [31:0] pl, logic [2:0] pr, logic la);
        t_token t;
        t.kind = kind;
        t.pl   = pl;
        t.pr   = pr;
        t.la   = la;
        tok_q.insert(tok_q.size(), t);
    endtask

    function automatic logic [31:0] pick_op_code();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return {24'd0, cur_minus};
        else if (r < 45)
            return {24'd0, cur_plus};
        else if (r < 75)
            return {24'd0, 8'($urandom)};
        return $urandom;
    endfunction

    task automatic add_op(bit sign);
        if (sign)
            add_tok(K_OP, {24'd0, $urandom_range(1) ? cur_minus : cur_plus},
                    3'($urandom), 1'($urandom));
        else
            add_tok(K_OP, pick_op_code(), 3'($urandom), 1'($urandom));
    endtask

    task automatic gen_term(int depth);
        int pick;
        if ($urandom_range(3) == 0)
            add_op(1'b1);
        pick = (depth >= 3) ? $urandom_range(1) : $urandom_range(3);
        case (pick)
            0: add_tok(K_VALUE, $urandom, 3'($urandom), 1'($urandom));
            1: add_tok(K_VAR, $urandom, 3'($urandom), 1'($urandom));
            2: begin
                add_tok(K_LPAR, $urandom, 3'($urandom), 1'($urandom));
                gen_expr(depth + 1);
                add_tok(K_RPAR, $urandom, 3'($urandom), 1'($urandom));
            end
            default: begin
                add_tok(K_FUNC, $urandom, 3'($urandom), 1'($urandom));
                add_tok(K_LPAR, $urandom, 3'($urandom), 1'($urandom));
                gen_expr(depth + 1);
                repeat ($urandom_range(2)) begin
                    add_tok(K_COMMA, $urandom, 3'($urandom), 1'($urandom));
                    gen_expr(depth + 1);
                end
                add_tok(K_RPAR, $urandom, 3'($urandom), 1'($urandom));
            end
        endcase
    endtask

    task automatic gen_expr(int depth);
        int n_terms;
        n_terms = $urandom_range(1, 3);
        for (int i = 0; i < n_terms; i++) begin
            if (i > 0)
                add_op(1'b0);
            gen_term(depth);
        end
    endtask

    // nesting without pops; right-assoc equal-precedence operators stay stacked
    task automatic gen_deep(int n);
        add_tok(K_VALUE, $urandom, 3'($urandom), 1'($urandom));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(2))
                0: add_tok(K_FUNC, $urandom, 3'($urandom), 1'($urandom));
                1: add_tok(K_LPAR, $urandom, 3'($urandom), 1'($urandom));
                default: add_tok(K_OP, {1'b1, 31'($urandom)}, 3'd4, 1'b0);
            endcase
        end
        add_tok($urandom_range(1) ? K_END : K_RPAR, $urandom, 3'($urandom), 1'($urandom));
    endtask

    task automatic gen_noise();
        logic [2:0] k;
        repeat ($urandom_range(1, 8)) begin
            k = 3'($urandom);
            add_tok(k, (k == K_OP) ? pick_op_code() : $urandom, 3'($urandom), 1'($urandom));
        end
    endtask

    task automatic send_token(t_token t);
        while ($urandom_range(99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {{(IN_TDATA_W-36){1'b0}}, t.la, t.pr, t.pl};
        s_tuser  <= t.kind;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send_tokens();
        foreach (tok_q[i])
            send_token(tok_q[i]);
        tok_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_idx   <= idx;
        cfg_wdata <= data;
        cfg_wen   <= 1'b1;
        @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] mcode, logic [7:0] pcode, logic [7:0] ucode,
                              logic [2:0] uprec);
        write_reg(CFG_MINUS, mcode);
        write_reg(CFG_PLUS, pcode);
        write_reg(CFG_UMINUS, ucode);
        write_reg(CFG_UPREC, {5'd0, uprec});
        cfg_wen <= 1'b0;
        @(posedge clk);
        cur_minus = mcode;
        cur_plus  = pcode;
    endtask

    task automatic run_random(int target, int tx, int rx);
        int start;
        int pick;
        tx_pct = tx;
        rx_pct = rx;
        start  = n_sent;
        while (n_sent - start < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                gen_expr(0);
                add_tok(K_END, $urandom, 3'($urandom), 1'($urandom));
            end else if (pick < 78) begin
                gen_deep($urandom_range(28, 36));
            end else begin
                gen_noise();
            end
            send_tokens();
        end
        drain();
    endtask

    task automatic directed();
        add_tok(K_VALUE, 32'h0000_0000, 3'd0, 1'b0);
        add_tok(K_OP, 32'd43, 3'd3, 1'b1);
        add_tok(K_OP, 32'd45, 3'd3, 1'b1);
        add_tok(K_OP, 32'd43, 3'd3, 1'b1);
        add_tok(K_VAR, 32'hFFFF_FFFF, 3'd7, 1'b1);
        add_tok(K_OP, 32'hFFFF_FFFF, 3'd7, 1'b0);
        add_tok(K_FUNC, 32'h1234_5678, 3'd0, 1'b0);
        add_tok(K_LPAR, 32'd0, 3'd0, 1'b0);
        add_tok(K_VALUE, 32'h3F80_0000, 3'd0, 1'b0);
        add_tok(K_COMMA, 32'd0, 3'd0, 1'b0);
        add_tok(K_OP, 32'd45, 3'd1, 1'b1);
        add_tok(K_VAR, 32'd3, 3'd0, 1'b0);
        add_tok(K_RPAR, 32'd0, 3'd0, 1'b0);
        add_tok(K_OP, 32'd42, 3'd0, 1'b1);
        add_tok(K_END, 32'd0, 3'd0, 1'b0);
        add_tok(K_RPAR, 32'd0, 3'd0, 1'b0);
        add_tok(K_LPAR, 32'd0, 3'd0, 1'b0);
        add_tok(K_VALUE, 32'd1, 3'd0, 1'b0);
        add_tok(K_END, 32'd0, 3'd0, 1'b0);
        add_tok(K_VALUE, 32'd2, 3'd0, 1'b0);
        add_tok(K_OP, 32'd42, 3'd0, 1'b1);
        add_tok(K_VALUE, 32'd3, 3'd0, 1'b0);
        add_tok(K_RPAR, 32'd0, 3'd0, 1'b0);
        add_tok(K_VALUE, 32'd4, 3'd0, 1'b0);
        add_tok(K_OP, 32'd43, 3'd3, 1'b1);
        add_tok(K_VALUE, 32'd5, 3'd0, 1'b0);
        add_tok(K_COMMA, 32'd0, 3'd0, 1'b0);
        add_tok(K_END, 32'd0, 3'd0, 1'b0);
        send_tokens();
        drain();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        run_random(50, 0, 0);

        set_config(8'd0, 8'd255, 8'd255, 3'd0);
        run_random(60, 48, 0);

        set_config(8'd255, 8'd0, 8'd0, 3'd7);
        run_random(60, 0, 48);

        // minus and plus sharing one code
        set_config(8'd42, 8'd42, 8'd1, 3'd3);
        run_random(60, 9, 9);

        // long output hold-off while a deep nest keeps the input busy
        set_config(MINUS_RST, PLUS_RST, UMINUS_RST, UPREC_RST);
        tx_pct   = 0;
        rx_pct   = 0;
        hold_req = 1'b1;
        gen_deep(34);
        send_tokens();
        run_random(40, 0, 0);

        set_config(8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
        run_random(60, 9, 9);

        $display("run covered %0d tokens and %0d postfix transactions, %0d of them errors",
                 n_sent, result_count, error_count);
        $display("six register settings, idle and stall patterns plus one long output hold-off");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/syi_pkg.sv
src/syi_ram.sv
src/syi_pop_unit.sv
src/shunting_yard_infix_to_postfix_top.sv
src/syi_checker.sv
verif/shunting_yard_infix_to_postfix_checker.sv
verif/shunting_yard_infix_to_postfix_top_test.sv
